// ----- src/stcm_pkg.sv -----
// ----------------------------------------------------------------------------
// stcm_pkg
// Shared constants, types and helpers of the segment tile congestion map.
// ----------------------------------------------------------------------------
package stcm_pkg;

  localparam int unsigned MAX_COLS   = 64;
  localparam int unsigned MAX_ROWS   = 64;
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned TSZ_W    = 23;
  localparam int unsigned CFG_CW   = 7;
  localparam int unsigned FRAC_SH  = 3;  // coordinates held in eighths

  localparam int unsigned COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned QW       = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned QCW      = (QW > 1) ? $clog2(QW) : 1;
  localparam int unsigned CNTC_W   = $clog2(MAX_COLS + 1);
  localparam int unsigned CNTR_W   = $clog2(MAX_ROWS + 1);
  localparam int unsigned GUARD_W  = $clog2(MAX_COLS + MAX_ROWS + 2);
  localparam int unsigned DEPTH    = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NUM_W    = 25;
  localparam int unsigned REM_W    =
    ((NUM_W > TSZ_W + QW) ? NUM_W : TSZ_W + QW) + 1;
  localparam int unsigned EDGE_W   = 32;

  typedef enum logic [2:0] {
    CFG_X_MIN = 3'd0,
    CFG_Y_MIN = 3'd1,
    CFG_X_MAX = 3'd2,
    CFG_Y_MAX = 3'd3,
    CFG_TILE_W = 3'd4,
    CFG_TILE_H = 3'd5,
    CFG_COLS  = 3'd6,
    CFG_ROWS  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                      start;
    logic signed [EDGE_W-1:0]  xe;
    logic signed [EDGE_W-1:0]  ye;
  } cor_req_t;

  typedef struct packed {
    logic done;
    logic pos;
    logic neg;
  } cor_res_t;

  function automatic logic [ADDR_W-1:0] tile_addr(logic [COL_W-1:0] c,
                                                  logic [ROW_W-1:0] r);
    tile_addr = ADDR_W'(c) * ADDR_W'(MAX_ROWS) + ADDR_W'(r);
  endfunction

endpackage

// ----- src/segment_tile_congestion_map_unit.sv -----
// ----------------------------------------------------------------------------
// segment_tile_congestion_map_unit
// Wire congestion counters over a tile grid, walked per segment.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  op, endpoints, flag, tile
//   out      output     out_valid_o / out_stall_i counts, tiles, clamped
//   cfg      input      cfg_valid_i / cfg_ready_o index, data
//
// after reset a clearing pass over all 4096 entries zeroes both counter memories
// a read item does one memory read
// an add item runs the four index divisions (a start, up to six quotient bits and
// a done each), one setup state, then per tile a read, a write and a check on a
// straight step or for the end tile, with a corner test added on a diagonal
// step (read-modify-write plus the shared corner multiplier)
// a waiting result is held in the output register while the next item runs
// ----------------------------------------------------------------------------
module segment_tile_congestion_map_unit
  import stcm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      op_i,
  input  logic signed [COORD_W-1:0] x_start_i,
  input  logic signed [COORD_W-1:0] y_start_i,
  input  logic signed [COORD_W-1:0] x_end_i,
  input  logic signed [COORD_W-1:0] y_end_i,
  input  logic                      is_critical_i,
  input  logic [5:0]                read_col_i,
  input  logic [5:0]                read_row_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [15:0]               wire_count_o,
  output logic [15:0]               critical_count_o,
  output logic [6:0]                tiles_touched_o,
  output logic                      clamped_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [2:0]                cfg_index_i,
  input  logic [COORD_W-1:0]        cfg_data_i
);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b00000000001,
    ST_IDLE  = 11'b00000000010,
    ST_DIV   = 11'b00000000100,
    ST_INIT  = 11'b00000001000,
    ST_RD    = 11'b00000010000,
    ST_WR    = 11'b00000100000,
    ST_TEST  = 11'b00001000000,
    ST_CHK   = 11'b00010000000,
    ST_ROP   = 11'b00100000000,
    ST_RWAIT = 11'b01000000000,
    ST_DONE  = 11'b10000000000
  } st_e;

  st_e state_q, state_d;

  // configuration
  logic signed [COORD_W-1:0] xmin_q, ymin_q, xmax_q, ymax_q;
  logic [TSZ_W-1:0]          tw_q, th_q;
  logic [CFG_CW-1:0]         ncols_q, nrows_q;

  // item
  logic                      op_q, crit_q;
  logic signed [COORD_W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [5:0]                rcol_q, rrow_q;
  logic [TSZ_W-1:0]          w_q, h_q;
  logic [CNTC_W-1:0]         nc_q;
  logic [CNTR_W-1:0]         nr_q;

  // walk
  logic [1:0]                k_q;
  logic                      div_run_q;
  logic [COL_W-1:0]          c_q, ec_q;
  logic [ROW_W-1:0]          r_q, er_q;
  logic signed [EDGE_W-1:0]  xl_q, yb_q;
  logic                      first_q, clip_q;
  logic [GUARD_W-1:0]        guard_q;
  logic [ADDR_W-1:0]         clr_q;

  // result
  logic                      out_valid_q;
  logic [15:0]               res_wire_q, res_crit_q;
  logic [15:0]               out_wire_q, out_crit_q;
  logic [6:0]                out_tiles_q;
  logic                      out_clip_q;

  logic in_acc, out_load;
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q  <= '0;
      ymin_q  <= '0;
      xmax_q  <= 24'sh7fffff;
      ymax_q  <= 24'sh7fffff;
      tw_q    <= TSZ_W'(1);
      th_q    <= TSZ_W'(1);
      ncols_q <= CFG_CW'(64);
      nrows_q <= CFG_CW'(64);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_X_MIN:  xmin_q  <= cfg_data_i;
        CFG_Y_MIN:  ymin_q  <= cfg_data_i;
        CFG_X_MAX:  xmax_q  <= cfg_data_i;
        CFG_Y_MAX:  ymax_q  <= cfg_data_i;
        CFG_TILE_W: tw_q    <= cfg_data_i[TSZ_W-1:0];
        CFG_TILE_H: th_q    <= cfg_data_i[TSZ_W-1:0];
        CFG_COLS:   ncols_q <= cfg_data_i[CFG_CW-1:0];
        CFG_ROWS:   nrows_q <= cfg_data_i[CFG_CW-1:0];
        default: ;
      endcase
    end
  end

  // endpoint clamp and offset for the operand in work
  logic signed [COORD_W-1:0] p_coord, p_lo, p_hi;
  logic [TSZ_W-1:0]          p_sz;
  logic [QW-1:0]             p_lim;
  logic signed [31:0]        v8, lo8, hi8, v_a, v_b, rel;
  logic                      p_clip;
  logic [NUM_W-1:0]          p_num;

  always_comb begin
    case (k_q)
      2'd0: begin
        p_coord = x1_q; p_lo = xmin_q; p_hi = xmax_q; p_sz = w_q;
        p_lim = QW'(nc_q - CNTC_W'(1));
      end
      2'd1: begin
        p_coord = y1_q; p_lo = ymin_q; p_hi = ymax_q; p_sz = h_q;
        p_lim = QW'(nr_q - CNTR_W'(1));
      end
      2'd2: begin
        p_coord = x2_q; p_lo = xmin_q; p_hi = xmax_q; p_sz = w_q;
        p_lim = QW'(nc_q - CNTC_W'(1));
      end
      default: begin
        p_coord = y2_q; p_lo = ymin_q; p_hi = ymax_q; p_sz = h_q;
        p_lim = QW'(nr_q - CNTR_W'(1));
      end
    endcase
    v8  = 32'(p_coord) <<< FRAC_SH;
    lo8 = 32'(p_lo) <<< FRAC_SH;
    hi8 = 32'(p_hi) <<< FRAC_SH;
    v_a = (p_coord < p_lo) ? lo8 : v8;
    v_b = (v_a > hi8) ? (hi8 - $signed({9'b0, p_sz})) : v_a;
    p_clip = (p_coord < p_lo) || (v_a > hi8);
    rel = v_b - lo8;
    p_num = rel[31] ? '0 : rel[NUM_W+FRAC_SH-1:FRAC_SH];
  end

  logic          div_start, div_done;
  logic [QW-1:0] div_q;
  assign div_start = (state_q == ST_DIV) && !div_run_q;

  stcm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (p_num),
    .den_i   (p_sz),
    .lim_i   (p_lim),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // step direction and corner
  logic c_lt, r_lt, c_eq, r_eq;
  assign c_lt = c_q < ec_q;
  assign r_lt = r_q < er_q;
  assign c_eq = c_q == ec_q;
  assign r_eq = r_q == er_q;

  cor_req_t cor_req;
  cor_res_t cor_res;
  logic     diag;
  assign diag          = !c_eq && !r_eq;
  assign cor_req.start = (state_q == ST_WR) && !first_q && diag;
  assign cor_req.xe    = c_lt ? (xl_q + $signed({9'b0, w_q})) : xl_q;
  assign cor_req.ye    = r_lt ? (yb_q + $signed({9'b0, h_q})) : yb_q;

  stcm_corner u_corner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .x1_i   (x1_q),
    .y1_i   (y1_q),
    .x2_i   (x2_q),
    .y2_i   (y2_q),
    .res_o  (cor_res)
  );

  logic zero_s, mv_c, mv_r;
  assign zero_s = !cor_res.pos && !cor_res.neg;
  assign mv_r   = zero_s || (r_lt ? cor_res.pos : cor_res.neg);
  assign mv_c   = zero_s || (r_lt ? cor_res.neg : cor_res.pos);

  // counter memories
  logic [ADDR_W-1:0]     bump_addr, raddr, waddr;
  logic [COUNT_BITS-1:0] wire_rd, crit_rd, sel_rd, inc, wdata;
  logic                  we_wire, we_crit, rd_ok;

  assign bump_addr = first_q ? tile_addr(ec_q, er_q) : tile_addr(c_q, r_q);
  assign rd_ok     = (int'(rcol_q) < MAX_COLS) && (int'(rrow_q) < MAX_ROWS);
  assign raddr     = (state_q == ST_ROP) ?
                     tile_addr(COL_W'(rcol_q), ROW_W'(rrow_q)) : bump_addr;
  assign sel_rd    = crit_q ? crit_rd : wire_rd;
  assign inc       = (sel_rd == '1) ? sel_rd : sel_rd + COUNT_BITS'(1);
  assign we_wire   = (state_q == ST_CLEAR) || ((state_q == ST_WR) && !crit_q);
  assign we_crit   = (state_q == ST_CLEAR) || ((state_q == ST_WR) && crit_q);
  assign waddr     = (state_q == ST_CLEAR) ? clr_q : bump_addr;
  assign wdata     = (state_q == ST_CLEAR) ? '0 : inc;

  stcm_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_wire_ram (
    .clk_i   (clk_i),
    .we_i    (we_wire),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (wire_rd)
  );

  stcm_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_crit_ram (
    .clk_i   (clk_i),
    .we_i    (we_crit),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (crit_rd)
  );

  logic [GUARD_W-1:0] walk_lim, tiles;
  logic               more;
  assign walk_lim = GUARD_W'(nc_q) + GUARD_W'(nr_q);
  assign more     = (!c_eq || !r_eq) && (guard_q < walk_lim);
  assign tiles    = guard_q + GUARD_W'(1);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = op_i ? ST_ROP : ST_DIV;
      ST_DIV:   if (div_done && k_q == 2'd3) state_d = ST_INIT;
      ST_INIT:  state_d = ST_RD;
      ST_RD:    state_d = ST_WR;
      ST_WR:    state_d = (!first_q && diag) ? ST_TEST : ST_CHK;
      ST_TEST:  if (cor_res.done) state_d = ST_CHK;
      ST_CHK:   state_d = more ? ST_RD : ST_DONE;
      ST_ROP:   state_d = ST_RWAIT;
      ST_RWAIT: state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      div_run_q   <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (in_acc) begin
        k_q       <= '0;
        div_run_q <= 1'b0;
      end else if (div_start) begin
        div_run_q <= 1'b1;
      end else if (div_done) begin
        div_run_q <= 1'b0;
        k_q       <= k_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q       <= op_i;
      crit_q     <= is_critical_i;
      x1_q       <= x_start_i;
      y1_q       <= y_start_i;
      x2_q       <= x_end_i;
      y2_q       <= y_end_i;
      rcol_q     <= read_col_i;
      rrow_q     <= read_row_i;
      w_q        <= (tw_q == '0) ? TSZ_W'(1) : tw_q;
      h_q        <= (th_q == '0) ? TSZ_W'(1) : th_q;
      nc_q       <= (ncols_q == '0) ? CNTC_W'(1) :
                    (int'(ncols_q) > MAX_COLS) ? CNTC_W'(MAX_COLS) : CNTC_W'(ncols_q);
      nr_q       <= (nrows_q == '0) ? CNTR_W'(1) :
                    (int'(nrows_q) > MAX_ROWS) ? CNTR_W'(MAX_ROWS) : CNTR_W'(nrows_q);
      clip_q     <= 1'b0;
      res_wire_q <= '0;
      res_crit_q <= '0;
    end
    if (div_done) begin
      clip_q <= clip_q | p_clip;
      case (k_q)
        2'd0:    c_q  <= COL_W'(div_q);
        2'd1:    r_q  <= ROW_W'(div_q);
        2'd2:    ec_q <= COL_W'(div_q);
        default: er_q <= ROW_W'(div_q);
      endcase
    end
    if (state_q == ST_INIT) begin
      xl_q    <= 32'(xmin_q) + $signed(32'(w_q) * 32'(c_q));
      yb_q    <= 32'(ymin_q) + $signed(32'(h_q) * 32'(r_q));
      first_q <= 1'b1;
      guard_q <= '0;
    end
    if (state_q == ST_WR) begin
      if (first_q) begin
        first_q <= 1'b0;
      end else begin
        guard_q <= guard_q + GUARD_W'(1);
        if (c_eq) begin
          r_q  <= r_lt ? r_q + ROW_W'(1) : r_q - ROW_W'(1);
          yb_q <= r_lt ? yb_q + $signed({9'b0, h_q}) : yb_q - $signed({9'b0, h_q});
        end else if (r_eq) begin
          c_q  <= c_lt ? c_q + COL_W'(1) : c_q - COL_W'(1);
          xl_q <= c_lt ? xl_q + $signed({9'b0, w_q}) : xl_q - $signed({9'b0, w_q});
        end
      end
    end
    if ((state_q == ST_TEST) && cor_res.done) begin
      if (mv_r) begin
        r_q  <= r_lt ? r_q + ROW_W'(1) : r_q - ROW_W'(1);
        yb_q <= r_lt ? yb_q + $signed({9'b0, h_q}) : yb_q - $signed({9'b0, h_q});
      end
      if (mv_c) begin
        c_q  <= c_lt ? c_q + COL_W'(1) : c_q - COL_W'(1);
        xl_q <= c_lt ? xl_q + $signed({9'b0, w_q}) : xl_q - $signed({9'b0, w_q});
      end
    end
    if (state_q == ST_RWAIT) begin
      res_wire_q <= rd_ok ? 16'(wire_rd) : '0;
      res_crit_q <= rd_ok ? 16'(crit_rd) : '0;
    end
    if (out_load) begin
      out_wire_q  <= res_wire_q;
      out_crit_q  <= res_crit_q;
      out_tiles_q <= op_q ? '0 : ((tiles > GUARD_W'(127)) ? 7'd127 : 7'(tiles));
      out_clip_q  <= op_q ? 1'b0 : clip_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign wire_count_o     = out_wire_q;
  assign critical_count_o = out_crit_q;
  assign tiles_touched_o  = out_tiles_q;
  assign clamped_o        = out_clip_q;

  a_we_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_wire || we_crit) |-> (state_q == ST_CLEAR || state_q == ST_WR))
    else $error("counter write outside clear or bump");

  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) |->
      (CNTC_W'(c_q) < nc_q && CNTR_W'(r_q) < nr_q &&
       CNTC_W'(ec_q) < nc_q && CNTR_W'(er_q) < nr_q))
    else $error("walk left the grid in use");

  a_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) |-> (guard_q <= walk_lim))
    else $error("walk ran past its step limit");

  a_div_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV && div_run_q))
    else $error("divider result with no division pending");

endmodule

// ----- src/stcm_ram.sv -----
// ----------------------------------------------------------------------------
// stcm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module stcm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- src/stcm_div.sv -----
// ----------------------------------------------------------------------------
// stcm_div
// Iterative tile index divider: one quotient bit per cycle, clamped to limit.
// ----------------------------------------------------------------------------
module stcm_div
  import stcm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [TSZ_W-1:0]  den_i,
  input  logic [QW-1:0]     lim_i,
  output logic              done_o,
  output logic [QW-1:0]     q_o
);

  logic             busy_q, sat_q, done_q;
  logic [REM_W-1:0] rem_q, dsh_q;
  logic [QCW-1:0]   cnt_q;
  logic [QW-1:0]    q_q, qo_q;
  logic             ge;
  logic [QW-1:0]    qn;
  logic [REM_W-1:0] den_top;

  assign den_top = REM_W'(den_i) << QW;
  assign ge      = rem_q >= dsh_q;
  assign qn      = sat_q ? '1 : (q_q | (ge ? (QW'(1) << cnt_q) : '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (sat_q || cnt_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= REM_W'(num_i);
      dsh_q <= REM_W'(den_i) << (QW - 1);
      cnt_q <= QCW'(QW - 1);
      q_q   <= '0;
      sat_q <= REM_W'(num_i) >= den_top;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q - QCW'(1);
      q_q   <= qn;
      if (sat_q || cnt_q == '0) begin
        qo_q <= (qn > lim_i) ? lim_i : qn;
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = qo_q;

endmodule

// ----- src/stcm_corner.sv -----
// ----------------------------------------------------------------------------
// stcm_corner
// Line versus tile corner test: sign of the cross-multiplied height error,
// two products through one shared multiplier.
// ----------------------------------------------------------------------------
module stcm_corner
  import stcm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cor_req_t                  req_i,
  input  logic signed [COORD_W-1:0] x1_i,
  input  logic signed [COORD_W-1:0] y1_i,
  input  logic signed [COORD_W-1:0] x2_i,
  input  logic signed [COORD_W-1:0] y2_i,
  output cor_res_t                  res_o
);

  logic               p1_q, p2_q, p3_q;
  logic signed [32:0] dx, dy, a1, b2, mul_a, mul_b;
  logic signed [65:0] prod_q, acc_q, mul;
  logic signed [66:0] n;
  cor_res_t           res_q;

  assign dx    = 33'(x2_i) - 33'(x1_i);
  assign dy    = 33'(y2_i) - 33'(y1_i);
  assign a1    = 33'(y1_i) - 33'(req_i.ye);
  assign b2    = 33'(req_i.xe) - 33'(x1_i);
  assign mul_a = p1_q ? a1 : dy;
  assign mul_b = p1_q ? dx : b2;
  assign mul   = mul_a * mul_b;
  assign n     = 67'(acc_q) + 67'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q  <= 1'b0;
      p2_q  <= 1'b0;
      p3_q  <= 1'b0;
      res_q <= '0;
    end else begin
      p1_q <= req_i.start;
      p2_q <= p1_q;
      p3_q <= p2_q;
      res_q.done <= p3_q;
      res_q.pos  <= p3_q && (dx != '0) && (n != '0) && (n[66] == dx[32]);
      res_q.neg  <= p3_q && (dx != '0) && (n != '0) && (n[66] != dx[32]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_q || p2_q) begin
      prod_q <= mul;
    end
    if (p2_q) begin
      acc_q <= prod_q;
    end
  end

  assign res_o = res_q;

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the segment tile congestion map against a behavioral predictor of
// the tile walk and the two counter stores. Directed segments and reads come
// first, then random phases under several grid settings, with random idling
// on both channels.
// ----------------------------------------------------------------------------
module tb
  import stcm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        op;
    logic [23:0] xs, ys, xe, ye;
    logic        crit;
    logic [5:0]  rcol, rrow;
  } seg_item_t;

  typedef struct {
    logic [15:0] wires, crits;
    logic [6:0]  touched;
    logic        clip;
  } map_result_t;

  class congestion_board;
    int unsigned wires [MAX_COLS*MAX_ROWS];
    int unsigned crits [MAX_COLS*MAX_ROWS];
    longint      x_min, y_min, x_max, y_max, tw, th, ncols, nrows;
    map_result_t pending[$];
    int          errors;
    int          checked;

    function void clear();
      foreach (wires[i]) begin
        wires[i] = 0;
        crits[i] = 0;
      end
      x_min = 0; y_min = 0; x_max = 8388607; y_max = 8388607;
      tw = 1; th = 1; ncols = 64; nrows = 64;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [23:0] d);
      case (idx)
        CFG_X_MIN: x_min = longint'($signed(d));
        CFG_Y_MIN: y_min = longint'($signed(d));
        CFG_X_MAX: x_max = longint'($signed(d));
        CFG_Y_MAX: y_max = longint'($signed(d));
        CFG_TILE_W: tw = d[22:0];
        CFG_TILE_H: th = d[22:0];
        CFG_COLS: ncols = d[6:0];
        CFG_ROWS: nrows = d[6:0];
        default: ;
      endcase
    endfunction

    function longint to_tile(longint c, longint lo, longint hi, longint sz,
                             longint cnt, inout bit clip);
      longint v, rel, idx;
      v = c * 8;
      if (c < lo) begin
        v = lo * 8;
        clip = 1;
      end
      if (v > hi * 8) begin
        v = hi * 8 - sz;
        clip = 1;
      end
      rel = v - lo * 8;
      if (rel < 0) return 0;
      idx = rel / (sz * 8);
      return (idx > cnt - 1) ? cnt - 1 : idx;
    endfunction

    function int corner_side(longint x1, longint y1, longint x2, longint y2,
                             longint ex, longint ey);
      longint dx, n;
      dx = x2 - x1;
      if (dx == 0) return 0;
      n = (y1 - ey) * dx + (y2 - y1) * (ex - x1);
      if (dx < 0) n = -n;
      return (n > 0) ? 1 : ((n < 0) ? -1 : 0);
    endfunction

    function void bump(longint c, longint r, bit crit);
      int a;
      if (c < 0 || c >= MAX_COLS || r < 0 || r >= MAX_ROWS) return;
      a = int'(c * MAX_ROWS + r);
      if (crit) begin
        if (crits[a] < 65535) crits[a]++;
      end else begin
        if (wires[a] < 65535) wires[a]++;
      end
    endfunction

    function void note_item(seg_item_t it);
      map_result_t res;
      longint w, h, nc, nr, x1, y1, x2, y2, c, r, ec, er, g, xl, yb, cnt;
      bit clip;
      int s;
      res = '{16'd0, 16'd0, 7'd0, 1'b0};
      if (it.op) begin
        res.wires = 16'(wires[it.rcol * MAX_ROWS + it.rrow]);
        res.crits = 16'(crits[it.rcol * MAX_ROWS + it.rrow]);
        pending.insert(pending.size(), res);
        return;
      end
      w = tw ? tw : 1;
      h = th ? th : 1;
      nc = (ncols < 1) ? 1 : ((ncols > MAX_COLS) ? MAX_COLS : ncols);
      nr = (nrows < 1) ? 1 : ((nrows > MAX_ROWS) ? MAX_ROWS : nrows);
      x1 = longint'($signed(it.xs)); y1 = longint'($signed(it.ys));
      x2 = longint'($signed(it.xe)); y2 = longint'($signed(it.ye));
      clip = 0;
      c = to_tile(x1, x_min, x_max, w, nc, clip);
      r = to_tile(y1, y_min, y_max, h, nr, clip);
      ec = to_tile(x2, x_min, x_max, w, nc, clip);
      er = to_tile(y2, y_min, y_max, h, nr, clip);
      bump(ec, er, it.crit);
      cnt = 1;
      for (g = 0; (c != ec || r != er) && g < nc + nr; g++) begin
        xl = x_min + w * c;
        yb = y_min + h * r;
        bump(c, r, it.crit);
        cnt++;
        if (c == ec) r += (r < er) ? 1 : -1;
        else if (r == er) c += (c < ec) ? 1 : -1;
        else if (c < ec && r < er) begin
          s = corner_side(x1, y1, x2, y2, xl + w, yb + h);
          if (s == 0) begin c++; r++; end else if (s > 0) r++; else c++;
        end else if (c < ec) begin
          s = corner_side(x1, y1, x2, y2, xl + w, yb);
          if (s == 0) begin c++; r--; end else if (s < 0) r--; else c++;
        end else if (r > er) begin
          s = corner_side(x1, y1, x2, y2, xl, yb);
          if (s == 0) begin c--; r--; end else if (s < 0) r--; else c--;
        end else begin
          s = corner_side(x1, y1, x2, y2, xl, yb + h);
          if (s == 0) begin c--; r++; end else if (s > 0) r++; else c--;
        end
      end
      res.touched = (cnt > 127) ? 7'd127 : cnt[6:0];
      res.clip = clip;
      pending.insert(pending.size(), res);
    endfunction

    function void check_result(map_result_t got);
      map_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $error("result with no expected item pending");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.wires !== exp_r.wires) begin
        $error("wire_count expected %0d got %0d", exp_r.wires, got.wires);
        errors++;
      end
      if (got.crits !== exp_r.crits) begin
        $error("critical_count expected %0d got %0d", exp_r.crits, got.crits);
        errors++;
      end
      if (got.touched !== exp_r.touched) begin
        $error("tiles_touched expected %0d got %0d", exp_r.touched, got.touched);
        errors++;
      end
      if (got.clip !== exp_r.clip) begin
        $error("clamped expected %0d got %0d", exp_r.clip, got.clip);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic op_i = 1'b0;
  logic signed [COORD_W-1:0] x_start_i = '0, y_start_i = '0, x_end_i = '0, y_end_i = '0;
  logic is_critical_i = 1'b0;
  logic [5:0] read_col_i = '0, read_row_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] wire_count_o, critical_count_o;
  logic [6:0] tiles_touched_o;
  logic clamped_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [COORD_W-1:0] cfg_data_i = '0;

  congestion_board board;
  bit   calm;
  int   n_segs, n_reads, n_phases;
  longint cycle;

  always #1 clk_i = ~clk_i;

  segment_tile_congestion_map_unit u_top (.*);

  initial begin
    cycle = 0;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle > 10000000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result side: random stall, compare on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_result('{wire_count_o, critical_count_o, tiles_touched_o, clamped_o});
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 15);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [23:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, d);
  endtask

  task automatic send(seg_item_t it);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= it.op;
    x_start_i <= it.xs; y_start_i <= it.ys;
    x_end_i <= it.xe; y_end_i <= it.ye;
    is_critical_i <= it.crit;
    read_col_i <= it.rcol; read_row_i <= it.rrow;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(it);
    if (it.op) n_reads++; else n_segs++;
  endtask

  task automatic add_seg(int xs, int ys, int xe, int ye, bit crit);
    send('{1'b0, xs[23:0], ys[23:0], xe[23:0], ye[23:0], crit, 6'd0, 6'd0});
  endtask

  task automatic read_tile(int c, int r);
    seg_item_t it;
    it = '{1'b1, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
           1'($urandom), c[5:0], r[5:0]};
    send(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic grid(int x0, int y0, int x1, int y1, int w, int h, int nc, int nr);
    write_reg(CFG_X_MIN, x0[23:0]);
    write_reg(CFG_Y_MIN, y0[23:0]);
    write_reg(CFG_X_MAX, x1[23:0]);
    write_reg(CFG_Y_MAX, y1[23:0]);
    write_reg(CFG_TILE_W, w[23:0]);
    write_reg(CFG_TILE_H, h[23:0]);
    write_reg(CFG_COLS, nc[23:0]);
    write_reg(CFG_ROWS, nr[23:0]);
    cfg_valid_i <= 1'b0;
    n_phases++;
  endtask

  function automatic int in_span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic random_phase(int count, int x0, int y0, int span_x, int span_y);
    int k, sel;
    for (k = 0; k < count; k++) begin
      calm = (k >= count / 2) && (k < count / 2 + count / 6);
      sel = $urandom_range(99);
      if (sel < 30) read_tile($urandom_range(63), $urandom_range(63));
      else if (sel < 85)
        add_seg(x0 + in_span(-span_x / 8, span_x + span_x / 8),
                y0 + in_span(-span_y / 8, span_y + span_y / 8),
                x0 + in_span(-span_x / 8, span_x + span_x / 8),
                y0 + in_span(-span_y / 8, span_y + span_y / 8), 1'($urandom));
      else add_seg($urandom, $urandom, $urandom, $urandom, 1'($urandom));
    end
    calm = 0;
  endtask

  initial begin
    board = new();
    board.clear();
    calm = 0;
    n_segs = 0; n_reads = 0; n_phases = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset grid, extremes of coordinates and clamping
    add_seg(0, 0, 0, 0, 0);
    add_seg(-8388608, -8388608, 8388607, 8388607, 1);
    add_seg(0, 0, 63, 63, 0);
    add_seg(63, 0, 0, 63, 1);
    read_tile(0, 0);
    read_tile(63, 63);
    read_tile(63, 0);
    drain();

    // small tiles: straight, diagonal, exact corner ties in all directions
    grid(-100, -50, 700, 400, 10, 8, 64, 40);
    add_seg(-100, -50, -100, 300, 0);
    add_seg(0, 0, 300, 0, 1);
    add_seg(-100, -50, 100, 110, 0);
    add_seg(100, 110, -100, -50, 1);
    add_seg(-100, 110, 100, -50, 0);
    add_seg(100, -50, -100, 110, 1);
    add_seg(5, 3, 533, 397, 0);
    add_seg(-9000, -9000, 9000, 9000, 1);
    read_tile(0, 0);
    read_tile(20, 20);
    read_tile(10, 10);
    read_tile(63, 39);
    drain();
    random_phase(400, -100, -50, 800, 450);
    drain();

    // degenerate: zero counts and tile sizes, max below min
    grid(500, 500, -500, -500, 0, 0, 0, 0);
    add_seg(0, 0, 1000, 1000, 0);
    add_seg(600, 600, 400, 400, 1);
    read_tile(0, 0);
    drain();
    random_phase(150, -600, -600, 1200, 1200);
    drain();

    // huge tiles, counts beyond maximum
    grid(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607, 127, 127);
    random_phase(250, -8388608, -8388608, 16777215 / 2, 16777215 / 2);
    drain();

    // coarse grid, then repeated bumps of one hot tile
    grid(0, 0, 1000, 1000, 100, 100, 4, 4);
    random_phase(400, 0, 0, 1000, 1000);
    repeat (120) add_seg(50, 50, 50, 50, 0);
    read_tile(0, 0);
    drain();

    grid(-3000, 2000, 5000, 9000, 7, 11, 64, 64);
    random_phase(350, -3000, 2000, 8000, 7000);
    drain();

    $display("%0d segments and %0d tile reads over %0d grid settings, %0d results checked",
             n_segs, n_reads, n_phases + 1, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/stcm_pkg.sv
src/stcm_ram.sv
src/stcm_div.sv
src/stcm_corner.sv
src/segment_tile_congestion_map_unit.sv
bench/tb.sv
